@@ hdl/tremor_band_rms_meter_assert.svh @@
// ----------------------------------------------------------------------------
// Tremor band RMS meter assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TREMOR_BAND_RMS_METER_ASSERT_SVH
`define TREMOR_BAND_RMS_METER_ASSERT_SVH

// The consequent must hold in the same cycle as the condition.
`define TBRM_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// The consequent must hold in the cycle after the condition.
`define TBRM_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ hdl/tbrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter package
// Shared widths, register map, fixed-point helpers and unit status type.
// ----------------------------------------------------------------------------
package tbrm_pkg;

   localparam int WINDOW_DEF = 50;

   localparam int AXIS_W  = 16;
   localparam int COEF_W  = 18;
   localparam int DATA_W  = 25;
   localparam int DELAY_W = 40;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int ACC_W   = 50;
   localparam int SQ_W    = 49;
   localparam int MSQ_W   = 32;
   localparam int ROOT_W  = 50;
   localparam int ROOT_TOP_BIT = ROOT_W - 2;
   localparam int OUT_W   = 25;

   localparam logic signed [COEF_W-1:0] HP_B0_RST = 18'sd54860;
   localparam logic signed [COEF_W-1:0] HP_A1_RST = -18'sd107968;
   localparam logic signed [COEF_W-1:0] HP_A2_RST = 18'sd45934;
   localparam logic signed [COEF_W-1:0] LP_B0_RST = 18'sd5984;
   localparam logic signed [COEF_W-1:0] LP_A1_RST = -18'sd64383;
   localparam logic signed [COEF_W-1:0] LP_A2_RST = 18'sd22785;

   localparam logic signed [ACC_W-1:0] DATA_HI  = 50'sd16777215;
   localparam logic signed [ACC_W-1:0] DATA_LO  = -50'sd16777216;
   localparam logic signed [ACC_W-1:0] DELAY_HI = 50'sd549755813887;
   localparam logic signed [ACC_W-1:0] DELAY_LO = -50'sd549755813888;
   localparam logic signed [ACC_W-1:0] RND_DATA  = 50'sd32768;
   localparam logic signed [ACC_W-1:0] RND_DELAY = 50'sd128;

   typedef enum logic [2:0] {
      REG_HP_B0 = 3'd0,
      REG_HP_A1 = 3'd1,
      REG_HP_A2 = 3'd2,
      REG_LP_B0 = 3'd3,
      REG_LP_A1 = 3'd4,
      REG_LP_A2 = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // Round half up from Q.24 to Q.8 and clamp to the data range.
   function automatic logic signed [DATA_W-1:0] round_sat_data(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      r = (acc + RND_DATA) >>> 16;
      if (r > DATA_HI) r = DATA_HI;
      else if (r < DATA_LO) r = DATA_LO;
      return r[DATA_W-1:0];
   endfunction

   // Round half up from Q.24 to Q.16 and clamp to the delay range.
   function automatic logic signed [DELAY_W-1:0] round_sat_delay(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      r = (acc + RND_DELAY) >>> 8;
      if (r > DELAY_HI) r = DELAY_HI;
      else if (r < DELAY_LO) r = DELAY_LO;
      return r[DELAY_W-1:0];
   endfunction

endpackage

@@ hdl/tbrm_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter shared multiplier
// Signed 25 by 25 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module tbrm_mul (
   input  logic                                 clock,
   input  logic signed [tbrm_pkg::DATA_W-1:0]   op_a,
   input  logic signed [tbrm_pkg::DATA_W-1:0]   op_b,
   output logic signed [tbrm_pkg::PROD_W-1:0]   prod
);

   logic signed [tbrm_pkg::PROD_W-1:0] prod_ff;
   logic signed [tbrm_pkg::PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/tbrm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter window divider
// Divides by the window length one byte of the dividend per cycle; each
// quotient digit comes from a reciprocal multiplication by a constant.
// ----------------------------------------------------------------------------
module tbrm_div #(
   parameter int WINDOW = tbrm_pkg::WINDOW_DEF,
   parameter int SUM_W  = tbrm_pkg::SQ_W + $clog2(tbrm_pkg::WINDOW_DEF)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [SUM_W-1:0]            dividend,
   output logic [SUM_W-1:0]            quotient,
   output tbrm_pkg::unit_stat_type     stat
);

   // The partial dividend is the running remainder with the next byte below
   // it. It stays under WINDOW*256, so with the reciprocal rounded up and a
   // shift of its width plus log2(WINDOW) the digit is exact.
   localparam int REM_W = $clog2(WINDOW + 1);
   localparam int T_W   = REM_W + 8;
   localparam int SH    = T_W + $clog2(WINDOW);
   localparam int M_W   = SH + 1;
   localparam int P_W   = T_W + M_W;
   localparam int DIG_N = (SUM_W + 7) / 8;
   localparam int NUM_W = 8 * DIG_N;
   localparam int CNT_W = $clog2(DIG_N + 1);
   localparam longint RECIP_L = ((longint'(1) << SH) + longint'(WINDOW) - longint'(1))
                                / longint'(WINDOW);
   localparam logic [P_W-1:0] RECIP   = P_W'(RECIP_L);
   localparam logic [T_W-1:0] DIVISOR = T_W'(WINDOW);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [T_W-1:0]   part;
   logic [P_W-1:0]   scaled;
   logic [7:0]       q_dig;
   logic [T_W-1:0]   diff;

   always_comb begin
      part    = {rem_ff, num_ff[NUM_W-1 -: 8]};
      scaled  = P_W'(part) * RECIP;
      q_dig   = scaled[SH +: 8];
      diff    = part - T_W'(q_dig) * DIVISOR;
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = NUM_W'(dividend);
         rem_in  = '0;
         cnt_in  = CNT_W'(DIG_N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-9:0], q_dig};
         rem_in = diff[REM_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = num_ff[SUM_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hdl/tbrm_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter integer square root
// Bit-pair restoring square root, truncated, one result bit per cycle.
// ----------------------------------------------------------------------------
module tbrm_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tbrm_pkg::ROOT_W-1:0]       operand,
   output logic [tbrm_pkg::OUT_W-1:0]        root,
   output tbrm_pkg::unit_stat_type           stat
);

   localparam int W = tbrm_pkg::ROOT_W;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] bit_ff, bit_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = operand;
         res_in  = '0;
         bit_in  = W'(1) << tbrm_pkg::ROOT_TOP_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root      = res_ff[tbrm_pkg::OUT_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hdl/tremor_band_rms_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter
// Magnitude, four-section biquad band-pass and windowed RMS of a 3-axis IMU.
// ----------------------------------------------------------------------------
// One req transfer carries an x/y/z accelerometer sample; one rsp transfer
// returns the windowed RMS of the band-passed vector magnitude in Q.8.
// The six biquad coefficients sit on the csr port at byte addresses 0..20
// and should only be written while no sample is in flight.
// Each sample runs from acceptance to a valid result through these steps in
// order: the squared magnitude, its root, the four sections (five steps each
// on the shared multiplier), the square and window update, the divide by
// WINDOW one byte of the running sum at a time, the final root and the load
// of the output register. The shared multiplier, root unit and divider set
// the pace; a new sample is accepted only when the sequencer is back in
// idle, so a sample is through before the next one is taken.
// The result sits in an output register, so the next sample is accepted
// while it waits; if the receiver still stalls when the next result is
// ready, the sequencer holds in its done state until the transfer happens.
// Reset clears the filter delays, the window valid bits, the running sum
// and write position, and restores every coefficient to its default.
// ----------------------------------------------------------------------------
module tremor_band_rms_meter #(
   parameter int WINDOW = tbrm_pkg::WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rms_level [24:0], zero fill above
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DATA_W  = tbrm_pkg::DATA_W;
   localparam int COEF_W  = tbrm_pkg::COEF_W;
   localparam int DELAY_W = tbrm_pkg::DELAY_W;
   localparam int ACC_W   = tbrm_pkg::ACC_W;
   localparam int SQ_W    = tbrm_pkg::SQ_W;
   localparam int AXIS_W  = tbrm_pkg::AXIS_W;
   localparam int MSQ_W   = tbrm_pkg::MSQ_W;
   localparam int SUM_W   = SQ_W + $clog2(WINDOW);
   localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
   localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(WINDOW) << (SQ_W - 1);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MAG    = 9'b000000010,
      ST_ROOT1  = 9'b000000100,
      ST_FILT   = 9'b000001000,
      ST_SQUARE = 9'b000010000,
      ST_WIN    = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_ROOT2  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] sec_ff, sec_in;

   // Configuration registers.
   logic signed [COEF_W-1:0] hp_b0_ff, hp_a1_ff, hp_a2_ff;
   logic signed [COEF_W-1:0] lp_b0_ff, lp_a1_ff, lp_a2_ff;
   logic                     csr_wr;

   // Sample and filter datapath.
   logic signed [AXIS_W-1:0]  ax_ff [3];
   logic [MSQ_W-1:0]          msq_ff, msq_in;
   logic signed [DATA_W-1:0]  in_ff, in_in;
   logic signed [DATA_W-1:0]  out_ff, out_in;
   logic signed [ACC_W-1:0]   p_ff, p_in;
   logic signed [DELAY_W-1:0] z1_ff [4];
   logic signed [DELAY_W-1:0] z2_ff [4];
   logic signed [DELAY_W-1:0] z1_new, z2_new;
   logic                      z1_we, z2_we;
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-1:0]   two_p;
   logic                      hp_sec;
   logic signed [COEF_W-1:0]  cf_b0, cf_a1, cf_a2;

   logic signed [DATA_W-1:0]          mul_a, mul_b;
   logic signed [tbrm_pkg::PROD_W-1:0] prod;

   // Window storage.
   logic [SQ_W-1:0]   win_mem [WINDOW];
   logic [WINDOW-1:0] win_valid_ff;
   logic [SQ_W-1:0]   win_rd_ff;
   logic              old_valid_ff;
   logic [PTR_W-1:0]  wpos_ff, wpos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq, old_sq;
   logic              win_we;

   // Shared units.
   logic                          root_start;
   logic [tbrm_pkg::ROOT_W-1:0]   root_operand;
   logic [tbrm_pkg::OUT_W-1:0]    root_val;
   tbrm_pkg::unit_stat_type       root_stat;
   logic                          div_start;
   logic [SUM_W-1:0]              div_quo;
   tbrm_pkg::unit_stat_type       div_stat;

   logic [tbrm_pkg::OUT_W-1:0] rsp_data_ff;
   logic                       rsp_valid_ff;
   logic                       out_free;

   // ------------------------------------------------------------------------
   // Register file. Only the low 18 bits of a write count.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_b0_ff <= tbrm_pkg::HP_B0_RST;
         hp_a1_ff <= tbrm_pkg::HP_A1_RST;
         hp_a2_ff <= tbrm_pkg::HP_A2_RST;
         lp_b0_ff <= tbrm_pkg::LP_B0_RST;
         lp_a1_ff <= tbrm_pkg::LP_A1_RST;
         lp_a2_ff <= tbrm_pkg::LP_A2_RST;
      end else if (csr_wr) begin
         unique case (tbrm_pkg::reg_index_type'(csr_paddr[4:2]))
            tbrm_pkg::REG_HP_B0: hp_b0_ff <= csr_pwdata[COEF_W-1:0];
            tbrm_pkg::REG_HP_A1: hp_a1_ff <= csr_pwdata[COEF_W-1:0];
            tbrm_pkg::REG_HP_A2: hp_a2_ff <= csr_pwdata[COEF_W-1:0];
            tbrm_pkg::REG_LP_B0: lp_b0_ff <= csr_pwdata[COEF_W-1:0];
            tbrm_pkg::REG_LP_A1: lp_a1_ff <= csr_pwdata[COEF_W-1:0];
            tbrm_pkg::REG_LP_A2: lp_a2_ff <= csr_pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (tbrm_pkg::reg_index_type'(csr_paddr[4:2]))
         tbrm_pkg::REG_HP_B0: csr_prdata = 32'(hp_b0_ff);
         tbrm_pkg::REG_HP_A1: csr_prdata = 32'(hp_a1_ff);
         tbrm_pkg::REG_HP_A2: csr_prdata = 32'(hp_a2_ff);
         tbrm_pkg::REG_LP_B0: csr_prdata = 32'(lp_b0_ff);
         tbrm_pkg::REG_LP_A1: csr_prdata = 32'(lp_a1_ff);
         tbrm_pkg::REG_LP_A2: csr_prdata = 32'(lp_a2_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Shared units.
   // ------------------------------------------------------------------------
   tbrm_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   tbrm_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (root_operand),
      .root    (root_val),
      .stat    (root_stat)
   );

   tbrm_div #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // ------------------------------------------------------------------------
   // Section coefficients. Sections 0 and 1 are high-pass, 2 and 3 low-pass.
   // ------------------------------------------------------------------------
   assign hp_sec = ~sec_ff[1];
   assign cf_b0  = hp_sec ? hp_b0_ff : lp_b0_ff;
   assign cf_a1  = hp_sec ? hp_a1_ff : lp_a1_ff;
   assign cf_a2  = hp_sec ? hp_a2_ff : lp_a2_ff;
   assign two_p  = p_ff <<< 1;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign sq       = prod[SQ_W-1:0];
   assign old_sq   = old_valid_ff ? win_rd_ff : '0;

   // ------------------------------------------------------------------------
   // Sequencer and datapath steering.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sec_in       = sec_ff;
      msq_in       = msq_ff;
      in_in        = in_ff;
      out_in       = out_ff;
      p_in         = p_ff;
      wpos_in      = wpos_ff;
      sum_in       = sum_ff;
      mul_a        = in_ff;
      mul_b        = DATA_W'(cf_b0);
      acc          = '0;
      z1_new       = '0;
      z2_new       = '0;
      z1_we        = 1'b0;
      z2_we        = 1'b0;
      win_we       = 1'b0;
      root_start   = 1'b0;
      root_operand = tbrm_pkg::ROOT_W'(msq_in);
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MAG;
               step_in  = '0;
            end
         end
         ST_MAG: begin
            // Square one axis per cycle and add the products as they land.
            case (step_ff)
               3'd0:    mul_a = DATA_W'(ax_ff[0]);
               3'd1:    mul_a = DATA_W'(ax_ff[1]);
               default: mul_a = DATA_W'(ax_ff[2]);
            endcase
            mul_b = mul_a;
            if (step_ff == 3'd0) begin
               msq_in = '0;
            end else begin
               msq_in = msq_ff + prod[MSQ_W-1:0];
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               root_start   = 1'b1;
               root_operand = tbrm_pkg::ROOT_W'(msq_in);
               state_in     = ST_ROOT1;
            end
         end
         ST_ROOT1: begin
            if (root_stat.done) begin
               in_in    = {root_val[DATA_W-9:0], 8'd0};
               sec_in   = '0;
               step_in  = '0;
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_a = in_ff;
                  mul_b = DATA_W'(cf_b0);
               end
               3'd1: begin
                  p_in = prod;
                  acc  = prod + {{(ACC_W-DELAY_W-8){z1_ff[sec_ff][DELAY_W-1]}},
                                 z1_ff[sec_ff], 8'd0};
                  out_in = tbrm_pkg::round_sat_data(acc);
               end
               3'd2: begin
                  mul_a = out_ff;
                  mul_b = DATA_W'(cf_a1);
               end
               3'd3: begin
                  mul_a = out_ff;
                  mul_b = DATA_W'(cf_a2);
                  // b1 = -2*b0 in a high-pass section, +2*b0 in a low-pass one.
                  acc = (hp_sec ? -two_p : two_p) - prod
                        + {{(ACC_W-DELAY_W-8){z2_ff[sec_ff][DELAY_W-1]}},
                           z2_ff[sec_ff], 8'd0};
                  z1_new = tbrm_pkg::round_sat_delay(acc);
                  z1_we  = 1'b1;
               end
               default: begin
                  acc    = p_ff - prod;
                  z2_new = tbrm_pkg::round_sat_delay(acc);
                  z2_we  = 1'b1;
                  in_in  = out_ff;
                  step_in = '0;
                  sec_in  = sec_ff + 2'd1;
                  if (sec_ff == 2'd3) begin
                     state_in = ST_SQUARE;
                  end
               end
            endcase
         end
         ST_SQUARE: begin
            mul_a    = in_ff;
            mul_b    = in_ff;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            win_we    = 1'b1;
            sum_in    = sum_ff - SUM_W'(old_sq) + SUM_W'(sq);
            wpos_in   = (wpos_ff == PTR_LAST) ? '0 : wpos_ff + PTR_W'(1);
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               root_start   = 1'b1;
               root_operand = tbrm_pkg::ROOT_W'(div_quo[SQ_W-1:0]);
               state_in     = ST_ROOT2;
            end
         end
         ST_ROOT2: begin
            if (root_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sec_ff       <= '0;
         wpos_ff      <= '0;
         sum_ff       <= '0;
         win_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sec_ff   <= sec_in;
         wpos_ff  <= wpos_in;
         sum_ff   <= sum_in;
         if (z1_we) begin
            z1_ff[sec_ff] <= z1_new;
         end
         if (z2_we) begin
            z2_ff[sec_ff] <= z2_new;
         end
         if (win_we) begin
            win_valid_ff[wpos_ff] <= 1'b1;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      msq_ff <= msq_in;
      in_ff  <= in_in;
      out_ff <= out_in;
      p_ff   <= p_in;
      if (req_tvalid && req_tready) begin
         ax_ff[0] <= req_tdata[15:0];
         ax_ff[1] <= req_tdata[31:16];
         ax_ff[2] <= req_tdata[47:32];
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= root_val;
      end
   end

   // Window memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[wpos_ff] <= sq;
      end
      win_rd_ff    <= win_mem[wpos_ff];
      old_valid_ff <= win_valid_ff[wpos_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 32'(rsp_data_ff);

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------
   `include "tremor_band_rms_meter_assert.svh"

   `TBRM_ASSERT_NOW(a_root_free, root_start, !root_stat.busy, "root unit restarted while busy")
   `TBRM_ASSERT_NOW(a_wpos_range, 1'b1, wpos_ff <= PTR_LAST, "window position out of range")
   `TBRM_ASSERT_NOW(a_sum_bound, state_ff == ST_IDLE, sum_ff <= SUM_MAX, "running sum too large")
   `TBRM_ASSERT_NEXT(a_div_to_root, div_stat.done, state_ff == ST_ROOT2, "divide done lost")

endmodule

@@ tb/tbrm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter checker
// Watches the sample and result channels and the register port, keeps its own
// model of the magnitude, the four biquad sections and the RMS window, and
// compares every result transfer with the oldest predicted level.
// ----------------------------------------------------------------------------
module tbrm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          levels_pending
);
   import tbrm_pkg::*;

   localparam int WIN = WINDOW_DEF;

   logic signed [63:0] coef [6];
   logic signed [63:0] dly_one [4];
   logic signed [63:0] dly_two [4];
   logic [63:0] sq_ring [WIN];
   int          ring_pos;
   logic [63:0] sq_total;
   logic [24:0] level_queue [$];

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // One DF2T section; the arithmetic shift floors like the design.
   function automatic logic signed [63:0] biquad(input int s, input logic signed [63:0] b0,
                                                 input logic signed [63:0] b1,
                                                 input logic signed [63:0] a1,
                                                 input logic signed [63:0] a2,
                                                 input logic signed [63:0] x);
      logic signed [63:0] acc, y;
      acc = b0 * x + dly_one[s] * 256;
      y = clamp((acc + 32768) >>> 16, -64'sd16777216, 64'sd16777215);
      acc = b1 * x - a1 * y + dly_two[s] * 256;
      dly_one[s] = clamp((acc + 128) >>> 8, -64'sd549755813888, 64'sd549755813887);
      acc = b0 * x - a2 * y;
      dly_two[s] = clamp((acc + 128) >>> 8, -64'sd549755813888, 64'sd549755813887);
      return y;
   endfunction

   function automatic logic [24:0] band_rms(input logic [47:0] d);
      logic signed [63:0] ax, ay, az, v, hb, lb;
      logic [63:0] msq, sq, lvl;
      ax = $signed(d[15:0]);
      ay = $signed(d[31:16]);
      az = $signed(d[47:32]);
      msq = ax * ax + ay * ay + az * az;
      v = $signed(int_root(msq)) * 256;
      hb = coef[REG_HP_B0];
      lb = coef[REG_LP_B0];
      v = biquad(0, hb, -2 * hb, coef[REG_HP_A1], coef[REG_HP_A2], v);
      v = biquad(1, hb, -2 * hb, coef[REG_HP_A1], coef[REG_HP_A2], v);
      v = biquad(2, lb, 2 * lb, coef[REG_LP_A1], coef[REG_LP_A2], v);
      v = biquad(3, lb, 2 * lb, coef[REG_LP_A1], coef[REG_LP_A2], v);
      sq = v * v;
      sq_total = sq_total - sq_ring[ring_pos] + sq;
      sq_ring[ring_pos] = sq;
      ring_pos = (ring_pos + 1) % WIN;
      lvl = int_root(sq_total / WIN);
      return lvl[24:0];
   endfunction

   always @(posedge clock) begin
      logic [24:0] want;
      if (reset) begin
         coef[REG_HP_B0] <= HP_B0_RST;
         coef[REG_HP_A1] <= HP_A1_RST;
         coef[REG_HP_A2] <= HP_A2_RST;
         coef[REG_LP_B0] <= LP_B0_RST;
         coef[REG_LP_A1] <= LP_A1_RST;
         coef[REG_LP_A2] <= LP_A2_RST;
         for (int i = 0; i < 4; i++) begin
            dly_one[i] = 0;
            dly_two[i] = 0;
         end
         for (int i = 0; i < WIN; i++) sq_ring[i] = 0;
         ring_pos = 0;
         sq_total = 0;
         level_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[4:2] < 6)
            coef[csr_paddr[4:2]] <= $signed(csr_pwdata[17:0]);
         if (req_tvalid && req_tready) level_queue.push_back(band_rms(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (level_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected rms_level %0d", rsp_tdata[24:0]);
               fail_count <= fail_count + 1;
            end else begin
               want = level_queue.pop_front();
               if (rsp_tdata[24:0] !== want) begin
                  if (fail_count < 10)
                     $display("rms_level mismatch: expected %0d actual %0d", want,
                              rsp_tdata[24:0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      levels_pending <= level_queue.size();
   end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tremor band RMS meter testbench
// Drives accelerometer samples and coefficient writes, idles both channel
// sides at random, and lets the checker judge every result transfer.
// ----------------------------------------------------------------------------
module tb;
   import tbrm_pkg::*;

   // The limit covers all 1342 samples of the run plus receiver stalls with a
   // wide margin.
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 0;
   logic        reset = 1;
   logic [47:0] req_tdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, levels_pending;
   int          cycle_count = 0;
   bit          steady = 0;   // no idling on either side while set

   always #10 clock = ~clock;

   tremor_band_rms_meter u_top (.*);

   tbrm_checker u_checker (.*);

   // The receiver stalls about a third of the time unless a steady stretch runs.
   always @(posedge clock) rsp_tready <= steady || ($urandom_range(0, 99) >= 33);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[tremor_band_rms_meter] ERROR");
         $finish;
      end
   end

   // One sample transfer; the sender may idle at random first. Valid stays
   // up after the transfer until the next sample or a drain takes it down.
   task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tdata  <= {az, ay, ax};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Waits until every predicted level has been returned and the block is idle.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (levels_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_coef(input reg_index_type idx, input logic [31:0] value);
      csr_psel   <= 1;
      csr_pwrite <= 1;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1: return 16'($urandom_range(0, 255)) - 16'd128;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_samples(input int count);
      for (int i = 0; i < count; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed samples: zero, axis extremes, then a burst that saturates.
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7FFF, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h8000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h7FFF);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h0001, 16'h0001, 16'h0001);
      send_sample(16'h5555, 16'hAAAA, 16'h5555);
      send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
      random_samples(300);
      drain();

      // Extreme coefficients drive the sections into saturation; upper bits of
      // the write data must be ignored.
      write_coef(REG_HP_B0, 32'hFFFE_0000 | 32'h1FFFF);
      write_coef(REG_HP_A1, 32'h0002_0000);
      write_coef(REG_HP_A2, 32'h0001_FFFF);
      write_coef(REG_LP_B0, 32'hFFFC_0000 | 32'h20000);
      write_coef(REG_LP_A1, 32'h0001_FFFF);
      write_coef(REG_LP_A2, 32'h0002_0000);
      steady = 1;
      random_samples(200);
      steady = 0;
      drain();

      // Random coefficients in two further phases.
      for (int p = 0; p < 2; p++) begin
         for (int r = 0; r < 6; r++) write_coef(reg_index_type'(r), $urandom());
         random_samples(200);
         drain();
      end

      // Back to the defaults for the tail of the run.
      write_coef(REG_HP_B0, 54860);
      write_coef(REG_HP_A1, -107968);
      write_coef(REG_HP_A2, 45934);
      write_coef(REG_LP_B0, 5984);
      write_coef(REG_LP_A1, -64383);
      write_coef(REG_LP_A2, 22785);
      random_samples(430);
      drain();

      if (fail_count == 0) begin
         $display("[tremor_band_rms_meter] OK");
      end else begin
         $display("[tremor_band_rms_meter] ERROR");
      end
      $finish;
   end
endmodule
